// ----- rtl/core/dot_bracket_pair_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOT_BRACKET_PAIR_MATCHER_ASSERT_SVH
`define DOT_BRACKET_PAIR_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define DBPM_ASSERT_NOW(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define DBPM_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- rtl/core/dbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbpm_pkg
// Widths, character codes and status codes of the dot-bracket pair matcher.
// ----------------------------------------------------------------------------
package dbpm_pkg;

   localparam int MaxLen = 4096;
   localparam int PosW   = $clog2(MaxLen);      // stack entry / 0-based position
   localparam int CntW   = $clog2(MaxLen) + 1;  // counts that reach MaxLen
   localparam int EposW  = 13;                  // 1-based error position

   // dot-bracket symbols
   localparam logic [7:0] ChOpenRound   = 8'h28;
   localparam logic [7:0] ChCloseRound  = 8'h29;
   localparam logic [7:0] ChOpenSquare  = 8'h5B;
   localparam logic [7:0] ChCloseSquare = 8'h5D;
   localparam logic [7:0] ChDot         = 8'h2E;

   // bases
   localparam logic [7:0] ChA = 8'h41;
   localparam logic [7:0] ChU = 8'h55;
   localparam logic [7:0] ChG = 8'h47;
   localparam logic [7:0] ChC = 8'h43;
   localparam logic [7:0] ChT = 8'h54;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_T_BASE     = 3'd1,
      ST_BAD_BASE   = 3'd2,
      ST_UNOPENED   = 3'd3,
      ST_BAD_SYMBOL = 3'd4,
      ST_UNCLOSED   = 3'd5,
      ST_TOO_LONG   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      SEQ_OK       = 2'd0,
      SEQ_T_BASE   = 2'd1,
      SEQ_BAD_BASE = 2'd2
   } seq_err_type;

endpackage

// ----- rtl/core/dbpm_stack_ram.sv -----
// ----------------------------------------------------------------------------
// dbpm_stack_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module dbpm_stack_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dot_bracket_pair_matcher.sv -----
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher
// Matches round and square brackets of a dot-bracket record against two
// position stacks held in RAM and reports pairs and a final record status.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------
//  req     | in  | req_tvalid/tready   | tdata: base, symbol; tlast: last
//  rsp     | out | rsp_tvalid/tready   | tdata: left_pos, right_pos, status,
//          |     |                     |        error_pos; tuser: pair_valid;
//          |     |                     |        tlast: is_final
//
//  One item per cycle sustained while rsp_tready is high; each result appears
//  in the cycle after its transfer, from the registered stack RAM read data.
//  Reset (synchronous, active high) clears counts, errors and the output
//  valid; the stack RAMs are not cleared, only entries below the counts are read.
//  A stalled result holds in the output stage; a new transfer is taken in
//  the same cycle the held result leaves.
// ----------------------------------------------------------------------------
module dot_bracket_pair_matcher
   import dbpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [7:0] base, [15:8] symbol
   input  logic        req_tlast,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [11:0] left_pos, [23:12] right_pos,
                                     // [26:24] status, [39:27] error_pos
   output logic        rsp_tuser,    // [0] pair_valid
   output logic        rsp_tlast
);

`include "dot_bracket_pair_matcher_assert.svh"

   // record state
   logic [CntW-1:0]  position_ff,     position_in;
   logic [CntW-1:0]  round_count_ff,  round_count_in;
   logic [CntW-1:0]  square_count_ff, square_count_in;
   logic [PosW-1:0]  round_bottom_ff, round_bottom_in;
   logic [PosW-1:0]  square_bottom_ff, square_bottom_in;
   seq_err_type      seq_err_ff,      seq_err_in;
   logic [EposW-1:0] seq_pos_ff,      seq_pos_in;
   status_type       str_err_ff,      str_err_in;
   logic [EposW-1:0] str_pos_ff,      str_pos_in;

   // output stage
   logic             s1_valid_ff,  s1_valid_in;
   logic             s1_pair_ff,   s1_pair_in;
   logic             s1_square_ff, s1_square_in;
   logic [PosW-1:0]  s1_right_ff,  s1_right_in;
   logic             s1_final_ff;
   status_type       s1_status_ff, s1_status_in;
   logic [EposW-1:0] s1_epos_ff,   s1_epos_in;

   // stack RAM ports
   logic            rnd_we, rnd_re, sqr_we, sqr_re;
   logic [PosW-1:0] rnd_waddr, rnd_raddr, sqr_waddr, sqr_raddr;
   logic [PosW-1:0] push_data, rnd_rdata, sqr_rdata;

   logic            accept;
   logic [7:0]      base, symbol;
   logic [CntW-1:0] here;
   logic [PosW-1:0] first_open;
   logic [PosW-1:0] left_pos;

   assign req_tready = !s1_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign base       = req_tdata[7:0];
   assign symbol     = req_tdata[15:8];
   assign here       = position_ff;
   assign push_data  = here[PosW-1:0];

   always_comb begin
      position_in      = position_ff;
      round_count_in   = round_count_ff;
      square_count_in  = square_count_ff;
      round_bottom_in  = round_bottom_ff;
      square_bottom_in = square_bottom_ff;
      seq_err_in       = seq_err_ff;
      seq_pos_in       = seq_pos_ff;
      str_err_in       = str_err_ff;
      str_pos_in       = str_pos_ff;
      rnd_we = 1'b0;  rnd_re = 1'b0;  sqr_we = 1'b0;  sqr_re = 1'b0;
      rnd_waddr = round_count_ff[PosW-1:0];
      sqr_waddr = square_count_ff[PosW-1:0];
      rnd_raddr = PosW'(round_count_ff - CntW'(1));
      sqr_raddr = PosW'(square_count_ff - CntW'(1));
      s1_pair_in   = 1'b0;
      s1_square_in = 1'b0;
      s1_status_in = ST_OK;
      s1_epos_in   = '0;
      first_open   = '0;

      if (here < CntW'(MaxLen)) begin
         // sticky sequence check, first offender wins
         if (seq_err_ff == SEQ_OK) begin
            if (base == ChT) begin
               seq_err_in = SEQ_T_BASE;
               seq_pos_in = EposW'(here + CntW'(1));
            end else if (base != ChA && base != ChU && base != ChG && base != ChC) begin
               seq_err_in = SEQ_BAD_BASE;
               seq_pos_in = EposW'(here + CntW'(1));
            end
         end
         // stacks freeze once a structure error is held
         if (str_err_ff == ST_OK) begin
            unique case (symbol)
               ChOpenRound: begin
                  if (round_count_ff < CntW'(MaxLen)) begin
                     rnd_we         = 1'b1;
                     round_count_in = round_count_ff + CntW'(1);
                     if (round_count_ff == '0) begin
                        round_bottom_in = push_data;
                     end
                  end
               end
               ChOpenSquare: begin
                  if (square_count_ff < CntW'(MaxLen)) begin
                     sqr_we          = 1'b1;
                     square_count_in = square_count_ff + CntW'(1);
                     if (square_count_ff == '0) begin
                        square_bottom_in = push_data;
                     end
                  end
               end
               ChCloseRound: begin
                  if (round_count_ff == '0) begin
                     str_err_in = ST_UNOPENED;
                     str_pos_in = EposW'(here + CntW'(1));
                  end else begin
                     rnd_re         = 1'b1;
                     round_count_in = round_count_ff - CntW'(1);
                     s1_pair_in     = 1'b1;
                  end
               end
               ChCloseSquare: begin
                  if (square_count_ff == '0) begin
                     str_err_in = ST_UNOPENED;
                     str_pos_in = EposW'(here + CntW'(1));
                  end else begin
                     sqr_re          = 1'b1;
                     square_count_in = square_count_ff - CntW'(1);
                     s1_pair_in      = 1'b1;
                     s1_square_in    = 1'b1;
                  end
               end
               ChDot: begin
               end
               default: begin
                  str_err_in = ST_BAD_SYMBOL;
                  str_pos_in = EposW'(here + CntW'(1));
               end
            endcase
         end
         position_in = here + CntW'(1);
      end else if (str_err_ff == ST_OK) begin
         // past the maximum length: flag once, ignore the item
         str_err_in = ST_TOO_LONG;
         str_pos_in = EposW'(MaxLen + 1);
      end

      if (req_tlast) begin
         // lowest open position over both stacks
         if (round_count_in != '0 && square_count_in != '0) begin
            first_open = (round_bottom_in < square_bottom_in) ? round_bottom_in
                                                              : square_bottom_in;
         end else if (round_count_in != '0) begin
            first_open = round_bottom_in;
         end else begin
            first_open = square_bottom_in;
         end
         if (str_err_in == ST_OK && (round_count_in != '0 || square_count_in != '0)) begin
            str_err_in = ST_UNCLOSED;
            str_pos_in = EposW'(first_open) + EposW'(1);
         end
         // sequence errors win over structure errors
         if (seq_err_in != SEQ_OK) begin
            s1_status_in = status_type'({1'b0, seq_err_in});
            s1_epos_in   = seq_pos_in;
         end else if (str_err_in != ST_OK) begin
            s1_status_in = str_err_in;
            s1_epos_in   = str_pos_in;
         end
         // drop the record state for the next record
         position_in     = '0;
         round_count_in  = '0;
         square_count_in = '0;
         seq_err_in      = SEQ_OK;
         seq_pos_in      = '0;
         str_err_in      = ST_OK;
         str_pos_in      = '0;
      end

      s1_right_in = s1_pair_in ? here[PosW-1:0] : '0;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         round_count_ff  <= '0;
         square_count_ff <= '0;
         seq_err_ff      <= SEQ_OK;
         seq_pos_ff      <= '0;
         str_err_ff      <= ST_OK;
         str_pos_ff      <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            position_ff     <= position_in;
            round_count_ff  <= round_count_in;
            square_count_ff <= square_count_in;
            seq_err_ff      <= seq_err_in;
            seq_pos_ff      <= seq_pos_in;
            str_err_ff      <= str_err_in;
            str_pos_ff      <= str_pos_in;
         end
      end
   end

   // payload registers, advance on each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         round_bottom_ff  <= round_bottom_in;
         square_bottom_ff <= square_bottom_in;
         s1_pair_ff       <= s1_pair_in;
         s1_square_ff     <= s1_square_in;
         s1_right_ff      <= s1_right_in;
         s1_final_ff      <= req_tlast;
         s1_status_ff     <= s1_status_in;
         s1_epos_ff       <= s1_epos_in;
      end
   end

   // A push writes at its transfer edge and a later pop reads at its own
   // edge, so the RAM already holds the entry; no bypass is needed.
   dbpm_stack_ram #(
      .DEPTH(MaxLen),
      .WIDTH(PosW)
   ) u_round_stack (
      .clock   (clock),
      .wr_en   (rnd_we && accept),
      .wr_addr (rnd_waddr),
      .wr_data (push_data),
      .rd_en   (rnd_re && accept),
      .rd_addr (rnd_raddr),
      .rd_data (rnd_rdata)
   );

   dbpm_stack_ram #(
      .DEPTH(MaxLen),
      .WIDTH(PosW)
   ) u_square_stack (
      .clock   (clock),
      .wr_en   (sqr_we && accept),
      .wr_addr (sqr_waddr),
      .wr_data (push_data),
      .rd_en   (sqr_re && accept),
      .rd_addr (sqr_raddr),
      .rd_data (sqr_rdata)
   );

   // RAM read data holds while the result is stalled (read only on transfer)
   assign left_pos = !s1_pair_ff ? '0 : (s1_square_ff ? sqr_rdata : rnd_rdata);

   assign rsp_tvalid = s1_valid_ff;
   assign rsp_tuser  = s1_pair_ff;
   assign rsp_tlast  = s1_final_ff;
   assign rsp_tdata  = {s1_epos_ff, s1_status_ff, s1_right_ff, left_pos};

   `DBPM_ASSERT_NOW(a_pos_range, 1'b1, position_ff <= CntW'(MaxLen),
      "position beyond maximum length")
   `DBPM_ASSERT_NOW(a_counts_le_pos, 1'b1,
      ({1'b0, round_count_ff} + {1'b0, square_count_ff}) <= {1'b0, position_ff},
      "open brackets exceed positions taken")
   `DBPM_ASSERT_NEXT(a_clear_on_last, accept && req_tlast,
      position_ff == '0 && round_count_ff == '0 && square_count_ff == '0,
      "record state not cleared after last item")
   `DBPM_ASSERT_NEXT(a_frozen_after_err, accept && !req_tlast && str_err_ff != ST_OK,
      $stable(round_count_ff) && $stable(square_count_ff),
      "stack moved after structure error")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dot-bracket pair matcher. A built-in predictor
// tracks both bracket stacks and the sticky sequence and structure errors.
// Each request transfer queues one expected response. A monitor checks every
// response transfer, field by field, against the oldest queued one. Stimulus
// is a short set of directed records, two records past the length limit, a
// forced output stall and a long run of random records with noise records
// mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import dbpm_pkg::*;

   localparam int ClkPeriod   = 10;
   localparam int ResetCycles = 10;
   localparam int RandomItems = 550;
   localparam int HoldCycles  = 64;     // forced output stall length
   localparam int StallLimit  = 1000;   // cycles without any transfer
   localparam int DrainCycles = 16;

   // One response as the block should present it.
   typedef struct packed {
      logic             pair_valid;
      logic [PosW-1:0]  left_pos;
      logic [PosW-1:0]  right_pos;
      logic             is_final;
      status_type       status;
      logic [EposW-1:0] error_pos;
   } match_result_type;

   // Receiver ready patterns, one chosen per stretch.
   typedef enum logic [1:0] {
      RX_STREAM,   // always ready
      RX_COIN,     // ready half the time
      RX_MOSTLY,   // rare stalls
      RX_SPARSE    // mostly stalled
   } rx_pattern_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;     // [7:0] base, [15:8] symbol
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [11:0] left_pos, [23:12] right_pos,
                                     // [26:24] status, [39:27] error_pos
   logic        rsp_tuser;           // [0] pair_valid
   logic        rsp_tlast;

   // Predictor state: one record in flight.
   logic [PosW-1:0]  round_opens  [MaxLen];
   logic [PosW-1:0]  square_opens [MaxLen];
   int unsigned      rec_pos;
   int unsigned      round_depth;
   int unsigned      square_depth;
   seq_err_type      seq_err;
   logic [EposW-1:0] seq_err_pos;
   status_type       struct_err;
   logic [EposW-1:0] struct_err_pos;

   match_result_type expected_matches [$];
   match_result_type want;

   int unsigned items_sent      = 0;
   int unsigned records_sent    = 0;
   int unsigned results_checked = 0;
   int unsigned pairs_seen      = 0;
   int unsigned mismatch_count  = 0;
   int unsigned idle_cycles     = 0;

   // Sender burst control.
   int unsigned burst_left = 0;
   bit          gaps_on    = 1'b1;

   // Receiver pattern control.
   bit             hold_request = 1'b0;
   int unsigned    hold_count   = 0;
   int unsigned    pattern_left = 0;
   rx_pattern_type rx_pattern   = RX_STREAM;

   dot_bracket_pair_matcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(ClkPeriod / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Drop all per-record state; stack contents stay, only counts matter.
   function automatic void start_record();
      rec_pos        = 0;
      round_depth    = 0;
      square_depth   = 0;
      seq_err        = SEQ_OK;
      seq_err_pos    = '0;
      struct_err     = ST_OK;
      struct_err_pos = '0;
   endfunction

   // Keep only the first structure error of a record.
   function automatic void note_structure_error(input status_type code,
                                                input int unsigned pos1);
      if (struct_err == ST_OK) begin
         struct_err     = code;
         struct_err_pos = EposW'(pos1);
      end
   endfunction

   // Work out the response to one accepted position and queue it.
   function automatic void predict_match(input logic [7:0] base_ch,
                                         input logic [7:0] sym_ch,
                                         input logic last_pos);
      match_result_type res;
      int unsigned      here;
      int unsigned      first_open;
      res  = '0;
      here = rec_pos;
      if (here < MaxLen) begin
         if (seq_err == SEQ_OK) begin
            if (base_ch == ChT) begin
               seq_err     = SEQ_T_BASE;
               seq_err_pos = EposW'(here + 1);
            end else if (base_ch != ChA && base_ch != ChU &&
                         base_ch != ChG && base_ch != ChC) begin
               seq_err     = SEQ_BAD_BASE;
               seq_err_pos = EposW'(here + 1);
            end
         end
         // Stacks freeze once a structure error is held.
         if (struct_err == ST_OK) begin
            case (sym_ch)
               ChOpenRound: begin
                  if (round_depth < MaxLen) begin
                     round_opens[PosW'(round_depth)] = PosW'(here);
                     round_depth++;
                  end
               end
               ChOpenSquare: begin
                  if (square_depth < MaxLen) begin
                     square_opens[PosW'(square_depth)] = PosW'(here);
                     square_depth++;
                  end
               end
               ChCloseRound: begin
                  if (round_depth == 0) begin
                     note_structure_error(ST_UNOPENED, here + 1);
                  end else begin
                     round_depth--;
                     res.pair_valid = 1'b1;
                     res.left_pos   = round_opens[PosW'(round_depth)];
                  end
               end
               ChCloseSquare: begin
                  if (square_depth == 0) begin
                     note_structure_error(ST_UNOPENED, here + 1);
                  end else begin
                     square_depth--;
                     res.pair_valid = 1'b1;
                     res.left_pos   = square_opens[PosW'(square_depth)];
                  end
               end
               ChDot: begin
               end
               default: begin
                  note_structure_error(ST_BAD_SYMBOL, here + 1);
               end
            endcase
         end
         if (res.pair_valid) begin
            res.right_pos = PosW'(here);
         end
         rec_pos = here + 1;
      end else begin
         // Past the limit: nothing but the length error is looked at.
         note_structure_error(ST_TOO_LONG, MaxLen + 1);
      end

      if (last_pos) begin
         if (struct_err == ST_OK && (round_depth != 0 || square_depth != 0)) begin
            // Report the earliest opener still waiting on either stack.
            first_open = 32'hFFFF_FFFF;
            if (round_depth != 0 && round_opens[0] < first_open) begin
               first_open = round_opens[0];
            end
            if (square_depth != 0 && square_opens[0] < first_open) begin
               first_open = square_opens[0];
            end
            note_structure_error(ST_UNCLOSED, first_open + 1);
         end
         // A sequence error outranks any structure error.
         if (seq_err != SEQ_OK) begin
            res.status    = (seq_err == SEQ_T_BASE) ? ST_T_BASE : ST_BAD_BASE;
            res.error_pos = seq_err_pos;
         end else if (struct_err != ST_OK) begin
            res.status    = struct_err;
            res.error_pos = struct_err_pos;
         end
         start_record();
      end
      res.is_final = last_pos;
      expected_matches.insert(expected_matches.size(), res);
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   function automatic logic [7:0] pick_base();
      case ($urandom_range(0, 3))
         0:       return ChA;
         1:       return ChU;
         2:       return ChG;
         default: return ChC;
      endcase
   endfunction

   // Offer one position, hold it until the transfer, then predict it.
   // Between bursts, drop valid for a random gap.
   task automatic send_item(input logic [7:0] base_ch, input logic [7:0] sym_ch,
                            input logic last_pos);
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {sym_ch, base_ch};
      req_tlast  <= last_pos;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_match(base_ch, sym_ch, last_pos);
      if (burst_left > 0) begin
         burst_left--;
      end
      items_sent++;
      if (last_pos) begin
         records_sent++;
      end
   endtask

   // Send a whole record given as base and symbol text; the last char ends it.
   task automatic send_text(input string bases, input string symbols);
      for (int i = 0; i < bases.len(); i++) begin
         send_item(bases[i], symbols[i], i == bases.len() - 1);
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Hold off on a pattern of its own; the forced stall is counted here.
   always @(negedge clock) begin
      if (hold_request && hold_count < HoldCycles) begin
         hold_count = hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 160);
         end else begin
            pattern_left = pattern_left - 1;
         end
         case (rx_pattern)
            RX_STREAM: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic void check_field(input string field,
                                       input logic [EposW-1:0] want_val,
                                       input logic [EposW-1:0] got_val);
      if (got_val !== want_val) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, want_val, got_val);
         mismatch_count++;
      end
   endfunction

   // Compare every response transfer with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            $display("%0t ns: response with nothing expected, expected none, actual %h/%b/%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_matches.pop_front();
            check_field("pair_valid", EposW'(want.pair_valid), EposW'(rsp_tuser));
            check_field("left_pos",   EposW'(want.left_pos),   EposW'(rsp_tdata[11:0]));
            check_field("right_pos",  EposW'(want.right_pos),  EposW'(rsp_tdata[23:12]));
            check_field("is_final",   EposW'(want.is_final),   EposW'(rsp_tlast));
            check_field("status",     EposW'(want.status),     EposW'(rsp_tdata[26:24]));
            check_field("error_pos",  want.error_pos,          rsp_tdata[39:27]);
            results_checked++;
            if (want.pair_valid) begin
               pairs_seen++;
            end
         end
      end
   end

   // Abort if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("%0t ns: no transfer for %0d cycles, %0d responses outstanding",
                     $time, StallLimit, expected_matches.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Both stack kinds, crossed pairs, a pair on the last position.
   task automatic test_pairs();
      send_text("AUGCA", "([.)]");
   endtask

   // T base, lowercase and out-of-range bases; pairs still reported after a
   // sequence error; a sequence error outranks an earlier structure error.
   task automatic test_sequence_errors();
      send_text("Ta", "()");
      send_item(8'h00, ChDot, 1'b1);
      send_item(8'hFF, 8'h00, 1'b1);
      send_text("GT", "])");
      send_item(ChT, ChCloseRound, 1'b1);
   endtask

   // Unopened close freezes pairing; bad symbol; unclosed openers report the
   // earliest open position across both stacks.
   task automatic test_structure_errors();
      send_text("ACG", "]()");
      send_item(ChA, ChOpenRound, 1'b0);
      send_item(ChU, 8'hFF, 1'b0);
      send_item(ChG, ChCloseRound, 1'b1);
      send_text("AUGC", ".[(.");
   endtask

   // Stall the response side for a long stretch while requests keep coming.
   task automatic test_backpressure();
      gaps_on      = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 24; i++) begin
         send_item(pick_base(), (i < 12) ? ChOpenRound : ChCloseRound, i == 23);
      end
      gaps_on = 1'b1;
   endtask

   // Deep stacks up to the last legal position, then positions past the
   // limit with junk that must be ignored; then a record whose early
   // structure error hides the length error.
   task automatic test_overlength();
      logic [7:0] sym_ch;
      for (int i = 0; i < MaxLen + 4; i++) begin
         if (i < 1024) begin
            sym_ch = ChOpenRound;
         end else if (i < 2048) begin
            sym_ch = ChCloseRound;
         end else if (i < 3072) begin
            sym_ch = ChOpenSquare;
         end else begin
            sym_ch = ChCloseSquare;
         end
         if (i < MaxLen) begin
            send_item(pick_base(), sym_ch, 1'b0);
         end else begin
            send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      i == MaxLen + 3);
         end
      end
      for (int i = 0; i <= MaxLen; i++) begin
         send_item(pick_base(), (i == 0) ? ChCloseRound : ChDot, i == MaxLen);
      end
   endtask

   // Mostly well-formed records with random content; some dirty ones carry
   // stray bases and symbols or leave openers behind; a few are pure noise.
   task automatic test_random_records();
      int unsigned sent;
      int unsigned len;
      int unsigned opens_r;
      int unsigned opens_s;
      int unsigned remaining;
      int unsigned pick;
      bit          dirty;
      bit          leave_open;
      bit          must_close;
      bit          may_open;
      logic [7:0]  base_ch;
      logic [7:0]  sym_ch;
      logic [7:0]  close_ch;
      sent = 0;
      while (sent < RandomItems) begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         i == len - 1);
            end
         end else begin
            len        = $urandom_range(1, 48);
            dirty      = ($urandom_range(0, 3) == 0);
            leave_open = dirty && ($urandom_range(0, 1) == 1);
            opens_r    = 0;
            opens_s    = 0;
            for (int i = 0; i < len; i++) begin
               remaining  = len - 1 - i;
               must_close = !leave_open && (opens_r + opens_s == remaining + 1);
               may_open   = leave_open || (opens_r + opens_s + 1 <= remaining);
               close_ch   = (opens_r > 0 && (opens_s == 0 || $urandom_range(0, 1) == 1)) ?
                            ChCloseRound : ChCloseSquare;
               pick       = $urandom_range(0, 99);
               if (must_close) begin
                  sym_ch = close_ch;
               end else if (pick < 30 && may_open) begin
                  sym_ch = (pick < 18) ? ChOpenRound : ChOpenSquare;
               end else if (pick < 65 && opens_r + opens_s > 0) begin
                  sym_ch = close_ch;
               end else begin
                  sym_ch = ChDot;
               end
               base_ch = pick_base();
               if (dirty && $urandom_range(0, 19) == 0) begin
                  base_ch = ($urandom_range(0, 1) == 1) ? ChT : 8'($urandom_range(0, 255));
               end
               if (dirty && $urandom_range(0, 19) == 0) begin
                  sym_ch = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                                       : ChCloseRound;
               end
               // Track what is actually open after this position.
               if (sym_ch == ChOpenRound) begin
                  opens_r++;
               end else if (sym_ch == ChOpenSquare) begin
                  opens_s++;
               end else if (sym_ch == ChCloseRound && opens_r > 0) begin
                  opens_r--;
               end else if (sym_ch == ChCloseSquare && opens_s > 0) begin
                  opens_s--;
               end
               send_item(base_ch, sym_ch, i == len - 1);
            end
         end
         sent += len;
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      start_record();
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pairs();
      test_sequence_errors();
      test_structure_errors();
      test_backpressure();
      test_overlength();
      test_random_records();

      // Release the request side and let every response come out.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d positions in %0d records, two of them past the %0d-position limit.",
               items_sent, records_sent, MaxLen);
      $display("Checked %0d responses (%0d pairs) through a %0d-cycle output stall; %0d mismatches.",
               results_checked, pairs_seen, HoldCycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
